FILE: rtl/core/positional_array_list_macros.svh
// Assertion helpers for the positional array list checker.
// Each macro samples on clk_i and is quiet while rst_ni is low.
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PAL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional array list check failed");

// Consequent must hold in the cycle after the antecedent.
`define PAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional array list check failed");

`endif

FILE: rtl/core/pal_pkg.sv
package pal_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ACT_W    = 3;
  localparam int POS_W    = 9;
  localparam int NAME_W   = 32;
  localparam int AGE_W    = 8;
  localparam int STAT_W   = 2;
  localparam int ENTRY_W  = NAME_W + AGE_W;
  // Wide enough for position, count and count+1 without wrapping.
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_GET    = 3'd0,
    ACT_LOCATE = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_APPEND = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_COUNT,
    PTR_POS,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_POS,
    RD_PTR,
    RD_PTR_DN,
    RD_PTR_UP
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_COUNT_NEW,
    WR_POS_NEW,
    WR_PTR_MEM
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLEAR
  } cnt_op_e;

  typedef struct packed {
    logic    req_load;
    ptr_op_e ptr_op;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    cnt_op_e cnt_op;
    logic    set_status;
    status_e status;
    logic    set_found;
    logic    capture_read;
    logic    out_load;
  } pal_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             bad_get;
    logic             bad_ins;
    logic             full;
    logic             ins_more;
    logic             del_more;
    logic             loc_end;
    logic             match;
    logic             out_free;
  } pal_sts_t;

endpackage

FILE: rtl/core/positional_array_list.sv
// Positional array list: an ordered list of up to CAPACITY (256) entries of a
// 32-bit name and an 8-bit age, addressed by one-based position. Each request
// beat carries an action (get, locate, insert, delete, append, clear) and
// gives exactly one result beat with a status, the locate hit position, the
// entry read by get, and the list length and empty flag after the request.
// Requests are handled one at a time; the next request is taken as soon as
// the previous one has been handed to the output register, even if that
// result beat is still waiting for out_ready_i. Get, append, clear and a bad
// position or full store need no walk; locate compares entries in order until
// the first match or the end of the list, insert moves the entries from the
// position to the end up by one (count - position + 1 of them), and delete
// moves the entries after the position down by one (count - position). A
// result beat still waiting in the output register holds the next one in its
// load step for as long as out_ready_i stays low. The walks are paced by the
// single entry store, which has one write and one registered read port, so
// every moved or scanned entry takes a read step and then a write or compare
// step. The store needs no clearing after reset: only positions up to the
// current length are ever read, and those have all been written.
module positional_array_list
  import pal_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [NAME_W-1:0] entry_name_i,
  input  logic [AGE_W-1:0]  entry_age_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [POS_W-1:0]  found_position_o,
  output logic [NAME_W-1:0] read_name_o,
  output logic [AGE_W-1:0]  read_age_o,
  output logic [POS_W-1:0]  entry_count_o,
  output logic              is_empty_o
);

  pal_cmd_t cmd;
  pal_sts_t sts;

  // Sequencer: walks each action through its read, write and compare steps
  pal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: request hold, length and walk pointer, entry store, result beat
  pal_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .action_i         (action_i),
    .position_i       (position_i),
    .entry_name_i     (entry_name_i),
    .entry_age_i      (entry_age_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .read_name_o      (read_name_o),
    .read_age_o       (read_age_o),
    .entry_count_o    (entry_count_o),
    .is_empty_o       (is_empty_o)
  );

endmodule

FILE: rtl/core/pal_ram.sv
module pal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/pal_ctrl.sv
module pal_ctrl
  import pal_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pal_sts_t sts_i,
  output pal_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_GET_WAIT = 4'd2;
  localparam logic [3:0] S_LOC_RD   = 4'd3;
  localparam logic [3:0] S_LOC_CMP  = 4'd4;
  localparam logic [3:0] S_INS_RD   = 4'd5;
  localparam logic [3:0] S_INS_WR   = 4'd6;
  localparam logic [3:0] S_DEL_RD   = 4'd7;
  localparam logic [3:0] S_DEL_WR   = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  logic [3:0] state_q, state_d;
  pal_cmd_t   cmd;

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.req_load = 1'b1;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_OUT;
        case (sts_i.act)
          ACT_GET: begin
            if (sts_i.bad_get) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
            end else begin
              cmd.rd_sel = RD_POS;
              state_d    = S_GET_WAIT;
            end
          end
          ACT_LOCATE: begin
            cmd.ptr_op = PTR_ZERO;
            state_d    = S_LOC_RD;
          end
          ACT_INSERT: begin
            if (sts_i.bad_ins) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
            end else if (sts_i.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.ptr_op = PTR_COUNT;
              state_d    = S_INS_RD;
            end
          end
          ACT_DELETE: begin
            if (sts_i.bad_get) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
            end else begin
              cmd.ptr_op = PTR_POS;
              state_d    = S_DEL_RD;
            end
          end
          ACT_APPEND: begin
            if (sts_i.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.wr_sel = WR_COUNT_NEW;
              cmd.cnt_op = CNT_INC;
            end
          end
          ACT_CLEAR: begin
            cmd.cnt_op = CNT_CLEAR;
          end
          default: begin
          end
        endcase
      end
      S_GET_WAIT: begin
        cmd.capture_read = 1'b1;
        state_d          = S_OUT;
      end
      S_LOC_RD: begin
        if (sts_i.loc_end) begin
          state_d = S_OUT;
        end else begin
          cmd.rd_sel = RD_PTR;
          state_d    = S_LOC_CMP;
        end
      end
      S_LOC_CMP: begin
        if (sts_i.match) begin
          cmd.set_found = 1'b1;
          state_d       = S_OUT;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_d    = S_LOC_RD;
        end
      end
      S_INS_RD: begin
        if (sts_i.ins_more) begin
          cmd.rd_sel = RD_PTR_DN;
          state_d    = S_INS_WR;
        end else begin
          cmd.wr_sel = WR_POS_NEW;
          cmd.cnt_op = CNT_INC;
          state_d    = S_OUT;
        end
      end
      S_INS_WR: begin
        cmd.wr_sel = WR_PTR_MEM;
        cmd.ptr_op = PTR_DEC;
        state_d    = S_INS_RD;
      end
      S_DEL_RD: begin
        if (sts_i.del_more) begin
          cmd.rd_sel = RD_PTR_UP;
          state_d    = S_DEL_WR;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_d    = S_OUT;
        end
      end
      S_DEL_WR: begin
        cmd.wr_sel = WR_PTR_MEM;
        cmd.ptr_op = PTR_INC;
        state_d    = S_DEL_RD;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

endmodule

FILE: rtl/core/pal_dp.sv
module pal_dp
  import pal_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [NAME_W-1:0] entry_name_i,
  input  logic [AGE_W-1:0]  entry_age_i,
  input  pal_cmd_t          cmd_i,
  output pal_sts_t          sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [POS_W-1:0]  found_position_o,
  output logic [NAME_W-1:0] read_name_o,
  output logic [AGE_W-1:0]  read_age_o,
  output logic [POS_W-1:0]  entry_count_o,
  output logic              is_empty_o
);

  // Request, held for the whole operation
  logic [ACT_W-1:0]  act_q;
  logic [POS_W-1:0]  pos_q;
  logic [NAME_W-1:0] name_q;
  logic [AGE_W-1:0]  age_q;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;

  // Pending result fields
  status_e           res_status_q;
  logic [POS_W-1:0]  res_found_q;
  logic [NAME_W-1:0] res_name_q;
  logic [AGE_W-1:0]  res_age_q;

  // Output register
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [POS_W-1:0]  out_found_q;
  logic [NAME_W-1:0] out_name_q;
  logic [AGE_W-1:0]  out_age_q;
  logic [POS_W-1:0]  out_count_q;
  logic              out_empty_q;

  logic [CMP_W-1:0]   pos_x, cnt_x, ptr_x;
  logic [CMP_W-1:0]   pos_m1, ptr_m1, ptr_p1;
  logic               ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
  logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

  assign pos_x  = CMP_W'(pos_q);
  assign cnt_x  = CMP_W'(count_q);
  assign ptr_x  = CMP_W'(ptr_q);
  assign pos_m1 = pos_x - CMP_W'(1);
  assign ptr_m1 = ptr_x - CMP_W'(1);
  assign ptr_p1 = ptr_x + CMP_W'(1);

  assign sts_o.act      = act_q;
  assign sts_o.bad_get  = (pos_x == '0) || (pos_x > cnt_x);
  assign sts_o.bad_ins  = (pos_x == '0) || (pos_x > cnt_x + CMP_W'(1));
  assign sts_o.full     = (count_q == CNT_W'(CAPACITY));
  assign sts_o.ins_more = (ptr_x >= pos_x);
  assign sts_o.del_more = (ptr_p1 < cnt_x);
  assign sts_o.loc_end  = (ptr_q == count_q);
  assign sts_o.match    = (ram_rd_data == {name_q, age_q});
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Memory port steering
  always_comb begin
    ram_rd_en   = (cmd_i.rd_sel != RD_NONE);
    ram_rd_addr = ptr_q[ADDR_W-1:0];
    case (cmd_i.rd_sel)
      RD_POS:    ram_rd_addr = pos_m1[ADDR_W-1:0];
      RD_PTR:    ram_rd_addr = ptr_q[ADDR_W-1:0];
      RD_PTR_DN: ram_rd_addr = ptr_m1[ADDR_W-1:0];
      RD_PTR_UP: ram_rd_addr = ptr_p1[ADDR_W-1:0];
      default:   ram_rd_addr = ptr_q[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    ram_wr_en   = (cmd_i.wr_sel != WR_NONE);
    ram_wr_addr = ptr_q[ADDR_W-1:0];
    ram_wr_data = {name_q, age_q};
    case (cmd_i.wr_sel)
      WR_COUNT_NEW: ram_wr_addr = count_q[ADDR_W-1:0];
      WR_POS_NEW:   ram_wr_addr = pos_m1[ADDR_W-1:0];
      WR_PTR_MEM: begin
        ram_wr_addr = ptr_q[ADDR_W-1:0];
        ram_wr_data = ram_rd_data;
      end
      default: ram_wr_addr = ptr_q[ADDR_W-1:0];
    endcase
  end

  pal_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  always_comb begin
    case (cmd_i.ptr_op)
      PTR_ZERO:  ptr_d = '0;
      PTR_COUNT: ptr_d = count_q;
      PTR_POS:   ptr_d = pos_m1[CNT_W-1:0];
      PTR_INC:   ptr_d = ptr_q + CNT_W'(1);
      PTR_DEC:   ptr_d = ptr_q - CNT_W'(1);
      default:   ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC:   count_d = count_q + CNT_W'(1);
      CNT_DEC:   count_d = count_q - CNT_W'(1);
      CNT_CLEAR: count_d = '0;
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= cmd_i.out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.req_load) begin
      act_q        <= action_i;
      pos_q        <= position_i;
      name_q       <= entry_name_i;
      age_q        <= entry_age_i;
      res_status_q <= ST_OK;
      res_found_q  <= '0;
      res_name_q   <= '0;
      res_age_q    <= '0;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.set_found) begin
        res_found_q <= ptr_p1[POS_W-1:0];
      end
      if (cmd_i.capture_read) begin
        res_name_q <= ram_rd_data[ENTRY_W-1:AGE_W];
        res_age_q  <= ram_rd_data[AGE_W-1:0];
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_name_q   <= res_name_q;
      out_age_q    <= res_age_q;
      out_count_q  <= cnt_x[POS_W-1:0];
      out_empty_q  <= (count_q == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign read_name_o      = out_name_q;
  assign read_age_o       = out_age_q;
  assign entry_count_o    = out_count_q;
  assign is_empty_o       = out_empty_q;

endmodule

FILE: rtl/core/pal_checker.sv
`include "positional_array_list_macros.svh"

module pal_checker
  import pal_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [STAT_W-1:0] status_o,
  input logic [POS_W-1:0]  found_position_o,
  input logic [NAME_W-1:0] read_name_o,
  input logic [AGE_W-1:0]  read_age_o,
  input logic [POS_W-1:0]  entry_count_o,
  input logic              is_empty_o
);

  `PAL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(entry_count_o))
  `PAL_ASSERT_SAME(a_empty_flag, out_valid_o, is_empty_o == (entry_count_o == '0))
  `PAL_ASSERT_SAME(a_found_in_list, out_valid_o, found_position_o <= entry_count_o)
  `PAL_ASSERT_SAME(a_fail_no_data, out_valid_o && (status_o != ST_OK), found_position_o == '0 && read_name_o == '0 && read_age_o == '0)
  `PAL_ASSERT_SAME(a_full_len, out_valid_o && (status_o == ST_FULL), entry_count_o == POS_W'(CAPACITY))

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

FILE: tb/tb.sv
module tb;
  import pal_pkg::*;

  // Action codes 6 and 7 are not in the package enum; the list ignores them.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  // The limit allows for every beat taking as long as the slowest request, a
  // walk of the whole store, plus the receiver's stalls, several times over.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int          HOLD_OFF_CYCLES = 400;

  // One result beat, field for field.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found_position;
    logic [NAME_W-1:0] read_name;
    logic [AGE_W-1:0]  read_age;
    logic [POS_W-1:0]  entry_count;
    logic              is_empty;
  } list_result_t;

  // Shadow copy of the list. Each accepted request beat is applied here and
  // the result it must produce is queued; result beats are checked in order.
  class shadow_list;
    logic [NAME_W-1:0] names [CAPACITY];
    logic [AGE_W-1:0]  ages  [CAPACITY];
    int                len;
    list_result_t      due_results [$];
    int                faults;

    function new();
      len    = 0;
      faults = 0;
    endfunction

    function void apply_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                logic [NAME_W-1:0] nm, logic [AGE_W-1:0] ag);
      list_result_t r;
      int           p;
      int           j;
      r        = '0;
      r.status = ST_OK;
      p        = int'(pos);
      case (act)
        ACT_GET: begin
          if (p < 1 || p > len) begin
            r.status = ST_BADPOS;
          end else begin
            r.read_name = names[p-1];
            r.read_age  = ages[p-1];
          end
        end
        ACT_LOCATE: begin
          for (j = 0; j < len && r.found_position == 0; j++) begin
            if (names[j] == nm && ages[j] == ag) r.found_position = POS_W'(j + 1);
          end
        end
        ACT_INSERT: begin
          // position check wins over the full check
          if (p < 1 || p > len + 1) begin
            r.status = ST_BADPOS;
          end else if (len >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (j = len; j >= p; j--) begin
              names[j] = names[j-1];
              ages[j]  = ages[j-1];
            end
            names[p-1] = nm;
            ages[p-1]  = ag;
            len++;
          end
        end
        ACT_DELETE: begin
          if (p < 1 || p > len) begin
            r.status = ST_BADPOS;
          end else begin
            for (j = p - 1; j + 1 < len; j++) begin
              names[j] = names[j+1];
              ages[j]  = ages[j+1];
            end
            len--;
          end
        end
        ACT_APPEND: begin
          if (len >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            names[len] = nm;
            ages[len]  = ag;
            len++;
          end
        end
        ACT_CLEAR: len = 0;
        default: ;
      endcase
      r.entry_count = POS_W'(len);
      r.is_empty    = (len == 0);
      due_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [NAME_W-1:0] exp_val,
                                logic [NAME_W-1:0] got_val);
      if (exp_val !== got_val) begin
        $error("%s: expected 'h%0h, got 'h%0h", field, exp_val, got_val);
        faults++;
      end
    endfunction

    function void check_reply(list_result_t got);
      list_result_t exp_r;
      if (due_results.size() == 0) begin
        $error("result beat with no request outstanding");
        faults++;
      end else begin
        exp_r = due_results.pop_front();
        compare_field("status",         exp_r.status,         got.status);
        compare_field("found_position", exp_r.found_position, got.found_position);
        compare_field("read_name",      exp_r.read_name,      got.read_name);
        compare_field("read_age",       exp_r.read_age,       got.read_age);
        compare_field("entry_count",    exp_r.entry_count,    got.entry_count);
        compare_field("is_empty",       exp_r.is_empty,       got.is_empty);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ACT_W-1:0]  action = '0;
  logic [POS_W-1:0]  position = '0;
  logic [NAME_W-1:0] entry_name = '0;
  logic [AGE_W-1:0]  entry_age = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  found_position;
  logic [NAME_W-1:0] read_name;
  logic [AGE_W-1:0]  read_age;
  logic [POS_W-1:0]  entry_count;
  logic              is_empty;

  shadow_list shadow = new();

  // Idle chances in percent, changed between phases.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // Set by the stimulus to start a long receiver hold-off; the receiver
  // process takes it over and counts it down on its own.
  int hold_req = 0;
  int hold_left = 0;
  int items_sent = 0;

  positional_array_list uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .position_i       (position),
    .entry_name_i     (entry_name),
    .entry_age_i      (entry_age),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .found_position_o (found_position),
    .read_name_o      (read_name),
    .read_age_o       (read_age),
    .entry_count_o    (entry_count),
    .is_empty_o       (is_empty)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: drive ready at the falling edge. A pending hold-off request
  // wins over the random stall pattern and keeps ready low for its length.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check every result beat at the rising edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      shadow.check_reply('{status, found_position, read_name, read_age,
                           entry_count, is_empty});
    end
  end

  // Offer one request beat: idle a random number of cycles first, then hold
  // valid and payload until the beat is taken, and apply it to the shadow.
  task automatic push_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic [NAME_W-1:0] nm, input logic [AGE_W-1:0] ag);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    position   <= pos;
    entry_name <= nm;
    entry_age  <= ag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.apply_request(act, pos, nm, ag);
    items_sent++;
  endtask

  // One random request. Keep the list short most of the time so that the
  // walking actions stay cheap; reuse stored entries so that locate hits and
  // duplicates exercise the first-match rule.
  task automatic random_request();
    int                n;
    int                roll;
    int                k;
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [NAME_W-1:0] nm;
    logic [AGE_W-1:0]  ag;
    n    = shadow.len;
    roll = $urandom_range(99);
    if (roll < 18)      act = ACT_GET;
    else if (roll < 36) act = ACT_LOCATE;
    else if (roll < 52) act = ACT_INSERT;
    else if (roll < 68) act = ACT_DELETE;
    else if (roll < 84) act = ACT_APPEND;
    else if (roll < 87) act = ACT_CLEAR;
    else if (roll < 90) act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    else                act = (n > 40) ? ACT_DELETE : ACT_APPEND;
    // shrink a list that has grown long
    if (n > 48 && roll >= 84) act = ACT_DELETE;

    roll = $urandom_range(99);
    if (roll < 8)       pos = POS_W'($urandom_range(511));
    else if (roll < 12) pos = '0;
    else if (roll < 16) pos = POS_W'(n + 1 + $urandom_range(1));
    else if (act == ACT_INSERT) pos = POS_W'($urandom_range(n + 1, 1));
    else if (n > 0)     pos = POS_W'($urandom_range(n, 1));
    else                pos = POS_W'(1);

    roll = $urandom_range(99);
    if (roll < 30 && n > 0) begin
      k  = $urandom_range(n - 1);
      nm = shadow.names[k];
      ag = shadow.ages[k];
      // same name, other age: must not count as a hit
      if (roll < 5) ag = ag ^ AGE_W'($urandom_range(255, 1));
    end else if (roll < 50) begin
      nm = NAME_W'($urandom_range(3));
      ag = AGE_W'($urandom_range(1));
    end else begin
      nm = $urandom;
      ag = AGE_W'($urandom_range(255));
    end
    push_request(act, pos, nm, ag);
  endtask

  // Append until the store is full; now and then repeat a stored entry.
  task automatic fill_to_capacity();
    int                k;
    logic [NAME_W-1:0] nm;
    logic [AGE_W-1:0]  ag;
    while (shadow.len < CAPACITY) begin
      nm = $urandom;
      ag = AGE_W'($urandom_range(255));
      if (shadow.len > 0 && $urandom_range(15) == 0) begin
        k  = $urandom_range(shadow.len - 1);
        nm = shadow.names[k];
        ag = shadow.ages[k];
      end
      push_request(ACT_APPEND, POS_W'($urandom_range(511)), nm, ag);
    end
  endtask

  // Walk the corners of a full store, then empty it.
  task automatic probe_full_store();
    push_request(ACT_APPEND, '0, $urandom, AGE_W'($urandom_range(255)));
    push_request(ACT_INSERT, POS_W'(1), $urandom, AGE_W'($urandom_range(255)));
    // valid end position but no room left
    push_request(ACT_INSERT, POS_W'(CAPACITY + 1), $urandom, '0);
    // bad position reported ahead of full
    push_request(ACT_INSERT, POS_W'(CAPACITY + 2), $urandom, '0);
    push_request(ACT_INSERT, '0, $urandom, '0);
    push_request(ACT_GET, POS_W'(CAPACITY), '0, '0);
    push_request(ACT_GET, POS_W'(CAPACITY + 1), '0, '0);
    // locate of the last entry (deepest hit unless repeated earlier), then a scan of the whole store
    push_request(ACT_LOCATE, '0, shadow.names[CAPACITY-1], shadow.ages[CAPACITY-1]);
    push_request(ACT_LOCATE, '0, $urandom, AGE_W'($urandom_range(255)));
    push_request(ACT_DELETE, POS_W'(CAPACITY), '0, '0);
    push_request(ACT_INSERT, POS_W'(1), $urandom, AGE_W'($urandom_range(255)));
    push_request(ACT_DELETE, POS_W'(1), '0, '0);
    push_request(ACT_APPEND, '0, $urandom, AGE_W'($urandom_range(255)));
    push_request(ACT_GET, POS_W'(1), '0, '0);
    push_request(ACT_CLEAR, '0, '0, '0);
  endtask

  // Timeout: end the run as failed if it has not finished by the limit.
  initial begin
    int unsigned ticks;
    ticks = 0;
    while (ticks < CYCLE_LIMIT) begin
      @(posedge clk);
      ticks++;
    end
    $display("positional_array_list: mismatch");
    $finish;
  end

  initial begin
    tx_idle_pct = 6;
    rx_idle_pct = 72;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, edges of position, insert at both ends and in
    // the middle, first-match locate, delete of the last entry, spare codes.
    push_request(ACT_GET,    POS_W'(1), '0, '0);
    push_request(ACT_DELETE, POS_W'(1), '0, '0);
    push_request(ACT_LOCATE, '0, '0, '0);
    push_request(ACT_INSERT, '0, '1, '1);
    push_request(ACT_INSERT, POS_W'(2), '1, '1);
    push_request(ACT_INSERT, POS_W'(1), '1, '1);
    push_request(ACT_APPEND, '1, '0, '0);
    push_request(ACT_INSERT, POS_W'(3), 32'hA5A5_A5A5, 8'h5A);
    push_request(ACT_INSERT, POS_W'(2), 32'h5A5A_5A5A, 8'hA5);
    push_request(ACT_APPEND, '0, '0, '0);
    push_request(ACT_GET,    POS_W'(1), '0, '0);
    push_request(ACT_GET,    POS_W'(5), '0, '0);
    push_request(ACT_GET,    POS_W'(6), '0, '0);
    push_request(ACT_GET,    '1, '0, '0);
    push_request(ACT_GET,    '0, '0, '0);
    push_request(ACT_LOCATE, '0, '0, '0);
    push_request(ACT_LOCATE, '0, 32'hA5A5_A5A5, 8'h5B);
    push_request(ACT_LOCATE, '0, '1, '0);
    push_request(ACT_DELETE, POS_W'(5), '0, '0);
    push_request(ACT_DELETE, POS_W'(1), '0, '0);
    push_request(ACT_SPARE_LO, '1, '1, '1);
    push_request(ACT_SPARE_HI, '0, '0, '0);
    push_request(ACT_CLEAR,  '1, '1, '1);
    push_request(ACT_GET,    POS_W'(1), '0, '0);

    // Phase one: sender rarely idles, receiver stalls most cycles.
    while (items_sent < 380) random_request();

    // Phase two: the other way round; fill the store once on the way.
    tx_idle_pct = 72;
    rx_idle_pct = 6;
    fill_to_capacity();
    probe_full_store();
    while (items_sent < 760) random_request();

    // Phase three: no idling. Start with a long receiver hold-off while the
    // sender keeps offering beats, so the block backs up and stalls input.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = HOLD_OFF_CYCLES;
    while (items_sent < 850) random_request();
    fill_to_capacity();
    probe_full_store();

    // Drop valid, drain the outstanding results, then watch for stray beats.
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.faults == 0) begin
      $display("positional_array_list: match");
    end else begin
      $display("positional_array_list: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/pal_pkg.sv
rtl/core/pal_ram.sv
rtl/core/pal_ctrl.sv
rtl/core/pal_dp.sv
rtl/core/positional_array_list.sv
rtl/core/pal_checker.sv
tb/tb.sv
